// ----- rtl/core/tsc_pkg.sv -----
// ============================================================================
// tsc_pkg
// Widths, divider constants and the per-item context of the Taylor-series
// sine/cosine pipeline.
// ============================================================================
package tsc_pkg;

    // Number of series terms (4 to 16).
    localparam int TERMS = 10;

    // Port fields.
    localparam int ANGLE_W    = 32;
    localparam int RESULT_W   = 32;
    localparam int ANGLE_FRAC = 28;

    // Term magnitudes are unsigned Q.48; the largest term stays below 2^57.
    localparam int FRAC_BITS = 48;
    localparam int OUT_SHIFT = FRAC_BITS - 30;
    localparam int MAG_W     = 57;
    // Square of the angle magnitude, Q.56, at most 2^62.
    localparam int XX_W      = 63;
    localparam int XX_FRAC   = 2 * ANGLE_FRAC;
    // Signed running sum, Q.48, magnitude below 2^60.
    localparam int SUM_W     = 61;
    // Rounded magnitude before saturation.
    localparam int RND_W     = SUM_W - OUT_SHIFT;

    // Term update product m * xx, split into 32-bit limbs.
    localparam int LIMB_W = 32;
    localparam int FULL_W = MAG_W + XX_W;
    localparam int PROD_W = FULL_W - XX_FRAC;

    // Division by n*(n-1) in chunks: each chunk step divides a NUM_W-bit
    // value {remainder, chunk} by reciprocal multiplication.
    localparam int NMAX    = 2 * TERMS - 1;
    localparam int DMAX    = NMAX * (NMAX - 1);
    localparam int DIV_L   = $clog2(DMAX + 1);
    localparam int NUM_W   = 31;
    localparam int CHUNK_W = NUM_W - DIV_L;
    localparam int TOP_W   = PROD_W - 2 * CHUNK_W;
    localparam int DIV_S   = NUM_W + DIV_L;
    localparam int RECIP_W = DIV_S;
    localparam int QP_W    = NUM_W + RECIP_W;

    // Operation select carried on the request side-band.
    localparam logic OP_COSINE = 1'b1;

    typedef struct packed {
        logic                    cosine;
        logic                    negate;
        logic [XX_W-1:0]         xx;
        logic signed [SUM_W-1:0] sum;
    } tsc_ctx_t;

    // floor(num / d) for num < 2^NUM_W, with recip = ceil(2^DIV_S / d).
    function automatic logic [NUM_W-1:0] recip_quot(
        input logic [NUM_W-1:0]   num,
        input logic [RECIP_W-1:0] recip
    );
        logic [QP_W-1:0] prod;
        prod = QP_W'(num) * QP_W'(recip);
        return prod[DIV_S +: NUM_W];
    endfunction

    // num - quot * d, which is below d.
    function automatic logic [DIV_L-1:0] chunk_rem(
        input logic [NUM_W-1:0] num,
        input logic [NUM_W-1:0] quot,
        input logic [DIV_L-1:0] div
    );
        logic [NUM_W-1:0] back;
        back = quot * NUM_W'(div);
        return DIV_L'(num - back);
    endfunction

endpackage

// ----- rtl/core/taylor_sine_cosine.sv -----
// ============================================================================
// taylor_sine_cosine
// Pipelined truncated Taylor-series sine and cosine in fixed point.
// ============================================================================
// Usage:
//   Requests enter on the slave stream: s_tdata carries the angle in radians
//   (signed Q3.28) and s_tuser selects the function (0 sine, 1 cosine).
//   Each request yields exactly one result on the master stream, m_tdata,
//   signed Q1.30, rounded half away from zero and saturated.
//   There is no range reduction; accuracy falls off beyond about 2*pi.
// Throughput and stages:
//   One request per cycle while s_tready is high. A result passes through
//   one input stage, seven stages per further term (partial products,
//   product sum, and, for the chunked divide by n*(n-1), three quotient
//   steps by reciprocal multiply and two remainder steps), three
//   stages to finish, round and saturate, and the output register.
// Reset:
//   rst_n clears every valid bit; the pipeline is empty and s_tready is high.
// Back-pressure:
//   When m_tready is low, the output register holds and a skid register
//   catches one more result. Once the skid register is full, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
// ============================================================================
module taylor_sine_cosine
    import tsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ANGLE_W-1:0]  s_tdata,   // [31:0] angle
    input  logic                s_tuser,   // [0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RESULT_W-1:0] m_tdata    // [31:0] result
);

    // Pipeline advance: every stage moves while the skid register is empty.
    logic adv;

    // Term boundaries: entry t carries term t and the sum of terms 0..t-1.
    wire                   bnd_vld [TERMS];
    wire tsc_ctx_t         bnd_ctx [TERMS];
    wire [MAG_W-1:0]       bnd_m   [TERMS];

    // ------------------------------------------------------------------
    // Input stage: magnitude, square, first term
    // ------------------------------------------------------------------
    logic               in_vld_reg;
    tsc_ctx_t           in_ctx_reg;
    logic [MAG_W-1:0]   in_m_reg;

    logic               in_cosine;
    logic               in_negative;
    logic [ANGLE_W-1:0] in_mag;
    logic [2*ANGLE_W-1:0] in_sq;
    tsc_ctx_t           in_ctx_next;
    logic [MAG_W-1:0]   in_m_next;

    assign in_cosine   = (s_tuser == OP_COSINE);
    assign in_negative = s_tdata[ANGLE_W-1];
    // The most negative angle maps to 2^31, which still fits unsigned.
    assign in_mag      = in_negative ? (~s_tdata + ANGLE_W'(1)) : s_tdata;
    assign in_sq       = in_mag * in_mag;

    always_comb
    begin
        in_ctx_next.cosine = in_cosine;
        // Sine is odd: fold the sign in at the end.
        in_ctx_next.negate = !in_cosine && in_negative;
        in_ctx_next.xx     = in_sq[XX_W-1:0];
        in_ctx_next.sum    = '0;
        if (in_cosine)
        begin
            in_m_next = MAG_W'(1) << FRAC_BITS;
        end
        else
        begin
            in_m_next = MAG_W'(in_mag) << (FRAC_BITS - ANGLE_FRAC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_ctx_reg <= in_ctx_next;
            in_m_reg   <= in_m_next;
        end
    end

    assign bnd_vld[0] = in_vld_reg;
    assign bnd_ctx[0] = in_ctx_reg;
    assign bnd_m[0]   = in_m_reg;

    // ------------------------------------------------------------------
    // Term stages: m_t = floor(floor(m_{t-1} * xx / 2^56) / (n*(n-1)))
    // ------------------------------------------------------------------
    for (genvar t = 1; t < TERMS; t++)
    begin : g_term
        localparam int N_SIN = 2 * t + 1;
        localparam int N_COS = 2 * t;
        localparam int D_SIN = N_SIN * (N_SIN - 1);
        localparam int D_COS = N_COS * (N_COS - 1);
        localparam logic [63:0] POW_S = 64'd1 << DIV_S;
        localparam logic [RECIP_W-1:0] M_SIN =
            RECIP_W'((POW_S + 64'(D_SIN) - 64'd1) / 64'(D_SIN));
        localparam logic [RECIP_W-1:0] M_COS =
            RECIP_W'((POW_S + 64'(D_COS) - 64'd1) / 64'(D_COS));
        // Signs alternate from the first term: odd terms subtract.
        localparam bit SUB_PREV = ((t - 1) % 2) == 1;

        // Partial products stage
        logic                         p_vld_reg;
        tsc_ctx_t                     p_ctx_reg;
        logic [2*LIMB_W-1:0]          p00_reg;
        logic [XX_W-1:0]              p01_reg;
        logic [MAG_W-1:0]             p10_reg;
        logic [FULL_W-2*LIMB_W-1:0]   p11_reg;
        // Product sum stage
        logic                         s_vld_reg;
        tsc_ctx_t                     s_ctx_reg;
        logic [PROD_W-1:0]            s_prod_reg;
        // Divide, top chunk quotient
        logic                         q0_vld_reg;
        tsc_ctx_t                     q0_ctx_reg;
        logic [NUM_W-1:0]             q0_num_reg;
        logic [TOP_W-1:0]             q0_quot_reg;
        logic [2*CHUNK_W-1:0]         q0_low_reg;
        // Divide, top chunk remainder
        logic                         r0_vld_reg;
        tsc_ctx_t                     r0_ctx_reg;
        logic [DIV_L-1:0]             r0_rem_reg;
        logic [TOP_W-1:0]             r0_quot_reg;
        logic [2*CHUNK_W-1:0]         r0_low_reg;
        // Divide, middle chunk quotient
        logic                         q1_vld_reg;
        tsc_ctx_t                     q1_ctx_reg;
        logic [NUM_W-1:0]             q1_num_reg;
        logic [TOP_W-1:0]             q1_hi_reg;
        logic [CHUNK_W-1:0]           q1_quot_reg;
        logic [CHUNK_W-1:0]           q1_low_reg;
        // Divide, middle chunk remainder
        logic                         r1_vld_reg;
        tsc_ctx_t                     r1_ctx_reg;
        logic [DIV_L-1:0]             r1_rem_reg;
        logic [TOP_W-1:0]             r1_hi_reg;
        logic [CHUNK_W-1:0]           r1_quot_reg;
        logic [CHUNK_W-1:0]           r1_low_reg;
        // Divide, low chunk quotient: the new term
        logic                         t_vld_reg;
        tsc_ctx_t                     t_ctx_reg;
        logic [MAG_W-1:0]             t_m_reg;

        logic [LIMB_W-1:0]            m_lo;
        logic [MAG_W-LIMB_W-1:0]      m_hi;
        logic [LIMB_W-1:0]            xx_lo;
        logic [XX_W-LIMB_W-1:0]       xx_hi;
        logic signed [SUM_W-1:0]      m_signed;
        tsc_ctx_t                     p_ctx_next;
        logic [2*LIMB_W-1:0]          p00_next;
        logic [XX_W-1:0]              p01_next;
        logic [MAG_W-1:0]             p10_next;
        logic [FULL_W-2*LIMB_W-1:0]   p11_next;
        logic [FULL_W-1:0]            full;
        logic [NUM_W-1:0]             q0_num_next;
        logic [NUM_W-1:0]             q0_q;
        logic [NUM_W-1:0]             q1_num_next;
        logic [NUM_W-1:0]             q1_q;
        logic [NUM_W-1:0]             q2_num;
        logic [NUM_W-1:0]             q2_q;
        logic [PROD_W-1:0]            quot_full;

        // Partial products of the previous term and the square; fold the
        // previous term into the running sum.
        assign m_lo  = bnd_m[t-1][LIMB_W-1:0];
        assign m_hi  = bnd_m[t-1][MAG_W-1:LIMB_W];
        assign xx_lo = bnd_ctx[t-1].xx[LIMB_W-1:0];
        assign xx_hi = bnd_ctx[t-1].xx[XX_W-1:LIMB_W];
        assign p00_next = m_lo * xx_lo;
        assign p01_next = m_lo * xx_hi;
        assign p10_next = m_hi * xx_lo;
        assign p11_next = m_hi * xx_hi;
        assign m_signed = $signed({{(SUM_W-MAG_W){1'b0}}, bnd_m[t-1]});

        always_comb
        begin
            p_ctx_next = bnd_ctx[t-1];
            if (SUB_PREV)
            begin
                p_ctx_next.sum = bnd_ctx[t-1].sum - m_signed;
            end
            else
            begin
                p_ctx_next.sum = bnd_ctx[t-1].sum + m_signed;
            end
        end

        // Full product; keep the Q.48 part.
        assign full = FULL_W'(p00_reg)
                    + (FULL_W'(p01_reg) << LIMB_W)
                    + (FULL_W'(p10_reg) << LIMB_W)
                    + (FULL_W'(p11_reg) << (2 * LIMB_W));

        // Chunked divide: each step works on {remainder, next chunk}.
        assign q0_num_next = NUM_W'(s_prod_reg[PROD_W-1 -: TOP_W]);
        assign q0_q = recip_quot(q0_num_next, s_ctx_reg.cosine ? M_COS : M_SIN);

        assign q1_num_next = {r0_rem_reg, r0_low_reg[2*CHUNK_W-1:CHUNK_W]};
        assign q1_q = recip_quot(q1_num_next, r0_ctx_reg.cosine ? M_COS : M_SIN);

        assign q2_num = {r1_rem_reg, r1_low_reg};
        assign q2_q = recip_quot(q2_num, r1_ctx_reg.cosine ? M_COS : M_SIN);
        assign quot_full = {r1_hi_reg, r1_quot_reg, q2_q[CHUNK_W-1:0]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_vld_reg  <= 1'b0;
                s_vld_reg  <= 1'b0;
                q0_vld_reg <= 1'b0;
                r0_vld_reg <= 1'b0;
                q1_vld_reg <= 1'b0;
                r1_vld_reg <= 1'b0;
                t_vld_reg  <= 1'b0;
            end
            else if (adv)
            begin
                p_vld_reg  <= bnd_vld[t-1];
                s_vld_reg  <= p_vld_reg;
                q0_vld_reg <= s_vld_reg;
                r0_vld_reg <= q0_vld_reg;
                q1_vld_reg <= r0_vld_reg;
                r1_vld_reg <= q1_vld_reg;
                t_vld_reg  <= r1_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_ctx_reg   <= p_ctx_next;
                p00_reg     <= p00_next;
                p01_reg     <= p01_next;
                p10_reg     <= p10_next;
                p11_reg     <= p11_next;

                s_ctx_reg   <= p_ctx_reg;
                s_prod_reg  <= full[FULL_W-1:XX_FRAC];

                q0_ctx_reg  <= s_ctx_reg;
                q0_num_reg  <= q0_num_next;
                q0_quot_reg <= q0_q[TOP_W-1:0];
                q0_low_reg  <= s_prod_reg[2*CHUNK_W-1:0];

                r0_ctx_reg  <= q0_ctx_reg;
                r0_rem_reg  <= chunk_rem(q0_num_reg, NUM_W'(q0_quot_reg),
                                         q0_ctx_reg.cosine ? DIV_L'(D_COS) : DIV_L'(D_SIN));
                r0_quot_reg <= q0_quot_reg;
                r0_low_reg  <= q0_low_reg;

                q1_ctx_reg  <= r0_ctx_reg;
                q1_num_reg  <= q1_num_next;
                q1_hi_reg   <= r0_quot_reg;
                q1_quot_reg <= q1_q[CHUNK_W-1:0];
                q1_low_reg  <= r0_low_reg[CHUNK_W-1:0];

                r1_ctx_reg  <= q1_ctx_reg;
                r1_rem_reg  <= chunk_rem(q1_num_reg, NUM_W'(q1_quot_reg),
                                         q1_ctx_reg.cosine ? DIV_L'(D_COS) : DIV_L'(D_SIN));
                r1_hi_reg   <= q1_hi_reg;
                r1_quot_reg <= q1_quot_reg;
                r1_low_reg  <= q1_low_reg;

                t_ctx_reg   <= r1_ctx_reg;
                t_m_reg     <= quot_full[MAG_W-1:0];
            end
        end

        assign bnd_vld[t] = t_vld_reg;
        assign bnd_ctx[t] = t_ctx_reg;
        assign bnd_m[t]   = t_m_reg;
    end

    // ------------------------------------------------------------------
    // Finish: last term, sign and rounding, saturation
    // ------------------------------------------------------------------
    localparam bit SUB_LAST = ((TERMS - 1) % 2) == 1;
    localparam logic [RND_W-1:0] POS_LIMIT = RND_W'({1'b0, {(RESULT_W-1){1'b1}}});
    localparam logic [RND_W-1:0] NEG_LIMIT = RND_W'(1) << (RESULT_W - 1);

    logic                    f1_vld_reg;
    logic                    f1_negate_reg;
    logic signed [SUM_W-1:0] f1_sum_reg;
    logic                    f2_vld_reg;
    logic                    f2_neg_reg;
    logic [RND_W-1:0]        f2_mag_reg;
    logic                    fin_vld_reg;
    logic [RESULT_W-1:0]     fin_data_reg;

    logic signed [SUM_W-1:0] last_m;
    logic signed [SUM_W-1:0] f1_sum_next;
    logic [SUM_W-1:0]        f2_abs;
    logic [SUM_W-1:0]        f2_rnd;
    logic [RESULT_W-1:0]     fin_data_next;

    assign last_m = $signed({{(SUM_W-MAG_W){1'b0}}, bnd_m[TERMS-1]});
    assign f1_sum_next = SUB_LAST ? (bnd_ctx[TERMS-1].sum - last_m)
                                  : (bnd_ctx[TERMS-1].sum + last_m);

    // Round the magnitude half away from zero; the sign of the result is the
    // sign of the sum, flipped for sine of a negative angle.
    assign f2_abs = f1_sum_reg[SUM_W-1] ? SUM_W'(-f1_sum_reg) : SUM_W'(f1_sum_reg);
    assign f2_rnd = f2_abs + (SUM_W'(1) << (OUT_SHIFT - 1));

    always_comb
    begin
        if (f2_neg_reg)
        begin
            if (f2_mag_reg > NEG_LIMIT)
            begin
                fin_data_next = {1'b1, {(RESULT_W-1){1'b0}}};
            end
            else
            begin
                fin_data_next = ~f2_mag_reg[RESULT_W-1:0] + RESULT_W'(1);
            end
        end
        else
        begin
            if (f2_mag_reg > POS_LIMIT)
            begin
                fin_data_next = {1'b0, {(RESULT_W-1){1'b1}}};
            end
            else
            begin
                fin_data_next = f2_mag_reg[RESULT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg  <= 1'b0;
            f2_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_vld_reg  <= bnd_vld[TERMS-1];
            f2_vld_reg  <= f1_vld_reg;
            fin_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_sum_reg    <= f1_sum_next;
            f1_negate_reg <= bnd_ctx[TERMS-1].negate;
            f2_neg_reg    <= f1_sum_reg[SUM_W-1] ^ f1_negate_reg;
            f2_mag_reg    <= f2_rnd[SUM_W-1:OUT_SHIFT];
            fin_data_reg  <= fin_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic                m_tvalid_reg;
    logic [RESULT_W-1:0] m_tdata_reg;
    logic                skid_vld_reg;
    logic [RESULT_W-1:0] skid_data_reg;
    logic                out_free;
    logic                incoming;

    assign adv      = !skid_vld_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign incoming = adv && fin_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // Drain the skid register first; it blocks new results.
            m_tvalid_reg <= skid_vld_reg || incoming;
            skid_vld_reg <= 1'b0;
        end
        else if (incoming)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            m_tdata_reg <= skid_vld_reg ? skid_data_reg : fin_data_reg;
        end
        if (!out_free && incoming)
        begin
            skid_data_reg <= fin_data_reg;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid register only holds a result behind a waiting output.
    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> m_tvalid_reg)
        else $error("skid register full while output register empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid register filled without a stall");

    // A finished result leaving the pipeline into a stalled output is caught.
    a_result_caught: assert property (@(posedge clk) disable iff (!rst_n)
        fin_vld_reg && adv && m_tvalid_reg && !m_tready |=> skid_vld_reg)
        else $error("result dropped at stalled output");

    // A taken output frees the skid register in the next cycle.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg && m_tready |=> !skid_vld_reg && m_tvalid_reg)
        else $error("skid register did not drain");

endmodule
